// File: src/bpmq_pkg.sv
// Package for the bounded priority message queue: transaction structs,
// opcodes, status codes, the per-cell entry and control types, and byte helpers.
// No dependencies.
`default_nettype none

package bpmq_pkg;

  localparam int unsigned PAYLOAD_BYTES = 8;
  localparam int unsigned PAYLOAD_W     = 64;
  localparam int unsigned LEN_W         = 4;
  localparam int unsigned PRIO_W        = 8;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned LIMIT_RESET   = 16;

  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_RECEIVE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_LEN = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic REG_QUEUE_LIMIT = 1'b0;

  typedef struct packed {
    logic [1:0]           op;
    logic [PRIO_W-1:0]    msg_priority;
    logic [PAYLOAD_W-1:0] payload;
    logic [LEN_W-1:0]     byte_count;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [LEN_W-1:0]     out_length;
    logic [PRIO_W-1:0]    out_priority;
    logic [CNT_W-1:0]     held_count;
  } out_t;

  typedef struct packed {
    logic [PRIO_W-1:0]    prio;
    logic [PAYLOAD_W-1:0] payload;
    logic [LEN_W-1:0]     len;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_HOLD = 3'b001,
    CMD_PUSH = 3'b010,
    CMD_POP  = 3'b100
  } cmd_t;

  typedef struct packed {
    cmd_t   cmd;
    entry_t fresh;
  } cell_ctrl_t;

  // Saturate a byte count to the payload width in bytes.
  function automatic logic [LEN_W-1:0] clamp_bytes(input logic [LEN_W-1:0] n);
    clamp_bytes = (n > LEN_W'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES) : n;
  endfunction

  // Mask that keeps the low n bytes of a payload word.
  function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    byte_mask = '0;
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      byte_mask[8*b +: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
    end
  endfunction

endpackage

`default_nettype wire

// File: src/bpmq_cell.sv
// One slot of the sorted shift-register queue.
// Depends on bpmq_pkg for the entry and control types.
`default_nettype none

module bpmq_cell
  import bpmq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     left_ent,
  input  logic       left_ge,
  input  entry_t     right_ent,
  input  logic       occupied,
  output entry_t     ent,
  output logic       ge
);

  entry_t ent_next;

  // A held entry of equal or higher priority stays ahead of a new one.
  assign ge = occupied && (ent.prio >= ctrl.fresh.prio);

  always_comb begin
    ent_next = ent;
    case (ctrl.cmd)
      CMD_PUSH: begin
        if (!ge) begin
          ent_next = left_ge ? ctrl.fresh : left_ent;
        end
      end
      CMD_POP: begin
        ent_next = right_ent;
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

`default_nettype wire

// File: src/bounded_priority_message_queue_core.sv
// Top level of the bounded priority message queue: command port, APB
// register port and a chain of bpmq_cell slots. Depends on bpmq_pkg.
`default_nettype none

// How to use this block:
// A command transaction (send, receive or clear) is taken at a rising edge
// where start is high and busy is low. busy stays low, so a new transaction
// may be issued on every clock.
// The result transaction appears on result in the cycle after acceptance,
// marked by done for exactly one cycle; the receiver cannot hold it off,
// so it must capture the result in that cycle.
// The messages sit in a row of DEPTH identical cells, slot 0 at the head.
// Every cell compares its priority with the incoming one in parallel, and on
// a send each cell either keeps its entry, takes the new one or takes its
// left neighbor's entry; on a receive every cell takes its right neighbor's.
// A single compare-and-shift step across the row thus serves each transaction.
// Among equal priorities, earlier sends stay ahead.
// The queue_limit register (byte address 0) caps how many messages are held; the
// user must write it over APB while no command transaction is in flight, which
// the block does not enforce. Reset (synchronous, active high) empties the queue,
// sets queue_limit to 16 and drops any pending result. No clearing pass is needed.

module bounded_priority_message_queue_core
  import bpmq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         cmd,
  output logic        done,
  output out_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CNT_W-1:0] queue_limit;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] limit_eff;
  logic             accept;
  cell_ctrl_t       ctrl;
  out_t             result_next;
  logic [LEN_W-1:0] send_len;
  logic [LEN_W-1:0] rx_len;

  entry_t ents [DEPTH];
  logic   ges  [DEPTH];

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUEUE_LIMIT) ? {{(32-CNT_W){1'b0}}, queue_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit <= CNT_W'(LIMIT_RESET);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_QUEUE_LIMIT)) begin
      queue_limit <= pwdata[CNT_W-1:0];
    end
  end

  // The block never stalls a command.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign limit_eff = (32'(queue_limit) > DEPTH) ? CNT_W'(DEPTH) : queue_limit;
  assign send_len  = clamp_bytes(cmd.byte_count);
  assign rx_len    = (clamp_bytes(cmd.byte_count) < ents[0].len) ?
                     clamp_bytes(cmd.byte_count) : ents[0].len;

  always_comb begin
    ctrl.cmd           = CMD_HOLD;
    ctrl.fresh.prio    = cmd.msg_priority;
    ctrl.fresh.payload = cmd.payload & byte_mask(send_len);
    ctrl.fresh.len     = send_len;
    count_next         = count;
    result_next        = '0;
    result_next.status = ST_OK;
    if (accept) begin
      case (cmd.op)
        OP_SEND: begin
          if (cmd.byte_count == '0) begin
            result_next.status = ST_ZERO_LEN;
          end else if (count >= limit_eff) begin
            result_next.status = ST_FULL;
          end else begin
            ctrl.cmd   = CMD_PUSH;
            count_next = count + 1'b1;
          end
        end
        OP_RECEIVE: begin
          if (count == '0) begin
            result_next.status = ST_EMPTY;
          end else begin
            ctrl.cmd                 = CMD_POP;
            count_next               = count - 1'b1;
            result_next.out_length   = rx_len;
            result_next.out_payload  = ents[0].payload & byte_mask(rx_len);
            result_next.out_priority = ents[0].prio;
          end
        end
        OP_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
    result_next.held_count = count_next;
  end

  // The chain of slots; only those below count hold live messages.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bpmq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_ent  ((i == 0) ? ctrl.fresh : ents[(i == 0) ? 0 : i-1]),
      .left_ge   ((i == 0) ? 1'b1 : ges[(i == 0) ? 0 : i-1]),
      .right_ent (ents[(i == DEPTH-1) ? i : i+1]),
      .occupied  (i < 32'(count)),
      .ent       (ents[i]),
      .ge        (ges[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // Fill level never passes the number of cells.
  assert property (@(posedge clk) disable iff (rst) 32'(count) <= DEPTH)
    else $error("message count exceeds the cell chain");

  // Every accepted command yields one result on the next cycle, and nothing else does.
  assert property (@(posedge clk) disable iff (rst) accept |=> done)
    else $error("accepted command produced no result");
  assert property (@(posedge clk) disable iff (rst) !accept |=> !done)
    else $error("result without a command");

  // The reported fill level tracks the internal count.
  assert property (@(posedge clk) disable iff (rst) done |-> result.held_count == count)
    else $error("held_count disagrees with the count");

  // An empty receive leaves the queue empty.
  assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_EMPTY) |-> result.held_count == '0)
    else $error("empty status with messages held");

endmodule

`default_nettype wire
